@@ design/gdtu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdtu_pkg
// Shared types and calendar constants for the receiver date/time to
// Unix seconds converter.
// ----------------------------------------------------------------------------
package gdtu_pkg;

    localparam int unsigned DigitW       = 4;
    localparam int unsigned SecW         = 32;
    localparam logic [SecW-1:0] Epoch2000Seconds = 32'd946684800;
    localparam logic [SecW-1:0] SecondsPerDay    = 32'd86400;
    localparam logic [SecW-1:0] SecondsPerYear   = 32'd31536000;
    localparam logic [7:0]      NumMonths        = 8'd12;
    localparam logic [7:0]      CenturyNoLeap    = 8'd100;

    // last field in the lowest bits
    typedef struct packed {
        logic [DigitW-1:0] second_units;
        logic [DigitW-1:0] second_tens;
        logic [DigitW-1:0] minute_units;
        logic [DigitW-1:0] minute_tens;
        logic [DigitW-1:0] hour_units;
        logic [DigitW-1:0] hour_tens;
        logic [DigitW-1:0] year_units;
        logic [DigitW-1:0] year_tens;
        logic [DigitW-1:0] month_units;
        logic [DigitW-1:0] month_tens;
        logic [DigitW-1:0] day_units;
        logic [DigitW-1:0] day_tens;
    } date_time_t;

    typedef struct packed {
        logic            bad_month;
        logic [SecW-1:0] unix_seconds;
    } result_t;

    // cumulative days before a month, month 1..12
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ design/gnss_date_time_to_unix_seconds.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_date_time_to_unix_seconds
// Path: input register, conversion logic, result register; an accepted item
//   is offered on the output once it is captured in the result register.
// Throughput: one item per cycle while m_tready allows; single conversion stage.
// Reset: synchronous active-low aresetn clears both valid flags; no other state.
// ----------------------------------------------------------------------------
module gnss_date_time_to_unix_seconds
    import gdtu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // day_tens, day_units, month_tens, month_units, year_tens, year_units,
    // hour_tens, hour_units, minute_tens, minute_units, second_tens,
    // second_units; 4 bits each from bit 0 up
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // unix_seconds
    output logic [31:0] m_tdata,
    // bad_month
    output logic        m_tuser
);

    date_time_t in_item_reg;
    logic       in_valid_reg;
    result_t    out_item_reg;
    logic       out_valid_reg;
    result_t    conv_result;
    logic       advance;

    gdtu_convert u_convert (
        .item_in    (in_item_reg),
        .result_out (conv_result)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= date_time_t'(s_tdata);
        end
        if (advance && in_valid_reg) begin
            out_item_reg <= conv_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg.unix_seconds;
    assign m_tuser  = out_item_reg.bad_month;

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted item not held in input stage");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !m_tvalid |=> m_tvalid)
        else $error("item did not reach result stage");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("valid flags not cleared by reset");

endmodule

@@ design/gdtu_convert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdtu_convert
// Combinational conversion of twelve date/time digits into seconds since
// 1970-01-01, modulo 2^32, plus a bad month flag.
// ----------------------------------------------------------------------------
module gdtu_convert
    import gdtu_pkg::*;
(
    input  date_time_t item_in,
    output result_t    result_out
);

    logic [7:0]  day;
    logic [7:0]  month;
    logic [7:0]  years;
    logic        bad;
    logic [8:0]  month_off;
    logic [8:0]  years_p3;
    logic [6:0]  leaps;
    logic        leap_now;
    logic        leap_add;
    logic [10:0] small_days;
    logic [SecW-1:0] days_ext;
    logic [SecW-1:0] day_secs;
    logic [SecW-1:0] year_secs;
    logic [SecW-1:0] hms_secs;

    always_comb begin
        day   = 8'(item_in.day_tens)   * 8'd10 + 8'(item_in.day_units);
        month = 8'(item_in.month_tens) * 8'd10 + 8'(item_in.month_units);
        years = 8'(item_in.year_tens)  * 8'd10 + 8'(item_in.year_units);

        bad       = (month == 8'd0) || (month > NumMonths);
        month_off = bad ? 9'd0 : days_before_month(month[3:0]);

        // leap years in [2000, 2000+years-1]; 2100 is the only century skipped
        years_p3 = 9'(years) + 9'd3;
        leaps    = 7'(years_p3 >> 2) - 7'(years > CenturyNoLeap);
        leap_now = (years[1:0] == 2'b00) && (years != CenturyNoLeap);
        leap_add = leap_now && (month != 8'd1) && (month != 8'd2);

        // day zero gives -1
        small_days = 11'(day) - 11'd1 + 11'(month_off) + 11'(leaps) + 11'(leap_add);
        days_ext   = {{(SecW-11){small_days[10]}}, small_days};

        day_secs  = days_ext * SecondsPerDay;
        year_secs = SecW'(years) * SecondsPerYear;
        hms_secs  = 32'(item_in.hour_tens)    * 32'd36000
                  + 32'(item_in.hour_units)   * 32'd3600
                  + 32'(item_in.minute_tens)  * 32'd600
                  + 32'(item_in.minute_units) * 32'd60
                  + 32'(item_in.second_tens)  * 32'd10
                  + 32'(item_in.second_units);

        result_out.unix_seconds = Epoch2000Seconds + day_secs + year_secs + hms_secs;
        result_out.bad_month    = bad;
    end

endmodule

@@ verif/gdtu_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdtu_result_checker
// Watches both stream channels of the date/time converter. Every accepted
// input item is converted to expected Unix seconds and a bad-month flag.
// Every accepted result is compared against the oldest pending expectation.
// ----------------------------------------------------------------------------
module gdtu_result_checker
    import gdtu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // day_tens, day_units, month_tens, month_units, year_tens, year_units,
    // hour_tens, hour_units, minute_tens, minute_units, second_tens,
    // second_units; 4 bits each from bit 0 up
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // unix_seconds
    input  logic [31:0] m_tdata,
    // bad_month
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending_count,
    output int          results_checked,
    output int          bad_month_results
);

    typedef struct packed {
        logic            bad_month;
        logic [SecW-1:0] seconds;
    } unix_time_t;

    localparam int unsigned DaysBeforeMonth [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    unix_time_t pending_times [$];

    function automatic int unsigned leaps_upto(input int unsigned y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    function automatic unix_time_t date_time_to_seconds(input logic [47:0] raw);
        date_time_t   dt;
        int unsigned  day;
        int unsigned  month;
        int unsigned  years;
        int unsigned  year;
        int unsigned  days;
        int unsigned  secs;
        logic         is_leap;
        unix_time_t   r;
        dt    = date_time_t'(raw);
        day   = dt.day_tens * 10 + dt.day_units;
        month = dt.month_tens * 10 + dt.month_units;
        years = dt.year_tens * 10 + dt.year_units;
        year  = 2000 + years;
        r.bad_month = (month < 1) || (month > 12);

        days = day - 1;
        if (!r.bad_month) begin
            days += DaysBeforeMonth[month - 1];
        end
        days += years * 365;
        days += leaps_upto(year - 1) - leaps_upto(1999);
        is_leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        if (month != 1 && month != 2 && is_leap) begin
            days += 1;
        end

        secs = Epoch2000Seconds + days * SecondsPerDay;
        secs += dt.hour_tens * 36000 + dt.hour_units * 3600;
        secs += dt.minute_tens * 600 + dt.minute_units * 60;
        secs += dt.second_tens * 10 + dt.second_units;
        r.seconds = secs;
        return r;
    endfunction

    always @(posedge aclk) begin
        unix_time_t want;
        if (!aresetn) begin
            fail_count        <= 0;
            results_checked   <= 0;
            bad_month_results <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_times.push_back(date_time_to_seconds(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                results_checked <= results_checked + 1;
                if (m_tuser) begin
                    bad_month_results <= bad_month_results + 1;
                end
                if (pending_times.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: unexpected result seconds=%0d bad_month=%0b",
                                 $realtime, m_tdata, m_tuser);
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    want = pending_times.pop_front();
                    if (m_tdata !== want.seconds || m_tuser !== want.bad_month) begin
                        if (fail_count < 10) begin
                            $display("%0t: mismatch seconds exp=%0d act=%0d,",
                                     $realtime, want.seconds, m_tdata);
                            $display("    bad_month exp=%0b act=%0b",
                                     want.bad_month, m_tuser);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count <= pending_times.size();
    end

endmodule

@@ verif/gnss_date_time_to_unix_seconds_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_date_time_to_unix_seconds_test
// Drives date/time digit items into the converter with random gaps on the
// input and random back-pressure on the output, including one long output
// hold-off. Directed calendar corner cases come first, then random dates,
// mostly well formed. Checking is done by gdtu_result_checker.
// ----------------------------------------------------------------------------
module gnss_date_time_to_unix_seconds_test;
    import gdtu_pkg::*;

    localparam int RandomItems  = 1800;
    localparam int IdleLimit    = 3000;
    localparam int HoldCycles   = 400;
    localparam int HoldAfter    = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    int fail_count;
    int pending_count;
    int results_checked;
    int bad_month_results;
    int items_sent = 0;
    int well_formed = 0;
    int idle_cycles = 0;
    bit held_off = 0;

    always #5 aclk = ~aclk;

    gnss_date_time_to_unix_seconds i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    gdtu_result_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .fail_count        (fail_count),
        .pending_count     (pending_count),
        .results_checked   (results_checked),
        .bad_month_results (bad_month_results)
    );

    function automatic logic [47:0] make_date_time(
        input int dd, input int mm, input int yy,
        input int hh, input int mi, input int ss
    );
        date_time_t dt;
        dt.day_tens     = 4'(dd / 10);
        dt.day_units    = 4'(dd % 10);
        dt.month_tens   = 4'(mm / 10);
        dt.month_units  = 4'(mm % 10);
        dt.year_tens    = 4'(yy / 10);
        dt.year_units   = 4'(yy % 10);
        dt.hour_tens    = 4'(hh / 10);
        dt.hour_units   = 4'(hh % 10);
        dt.minute_tens  = 4'(mi / 10);
        dt.minute_units = 4'(mi % 10);
        dt.second_tens  = 4'(ss / 10);
        dt.second_units = 4'(ss % 10);
        return dt;
    endfunction

    bit send_burst = 0;

    task automatic send_item(input logic [47:0] item);
        int gap;
        if ($urandom_range(0, 49) == 0) begin
            send_burst = ~send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // receiver: per-result stall, one long hold-off once traffic is flowing
    initial begin
        int  stall;
        bit  recv_burst;
        recv_burst = 0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                recv_burst = ~recv_burst;
            end
            stall = recv_burst ? 0 : $urandom_range(0, 11);
            if (!held_off && results_checked >= HoldAfter) begin
                held_off = 1;
                stall = HoldCycles;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("%0t: watchdog expired, %0d items still pending", $realtime,
                     pending_count);
            $display("gnss_date_time_to_unix_seconds regression: fail");
            $finish;
        end
    end

    initial begin
        int kind;
        date_time_t dt;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corners
        send_item(make_date_time(1, 1, 0, 0, 0, 0));
        send_item('0);
        send_item({48{1'b1}});
        send_item(make_date_time(29, 2, 24, 23, 59, 59));
        send_item(make_date_time(1, 3, 24, 0, 0, 0));
        send_item(make_date_time(0, 1, 0, 0, 0, 0));
        send_item(make_date_time(15, 0, 24, 12, 0, 0));
        send_item(make_date_time(15, 13, 24, 12, 0, 0));
        send_item(make_date_time(15, 13, 23, 12, 0, 0));
        send_item(make_date_time(1, 3, 100, 0, 0, 0));
        send_item(make_date_time(1, 3, 0, 0, 0, 0));
        for (int m = 1; m <= 12; m++) begin
            send_item(make_date_time(28, m, 4, 12, 34, 56));
        end
        send_item(make_date_time(31, 12, 99, 23, 59, 59));
        dt = make_date_time(7, 7, 7, 0, 0, 0);
        dt.hour_tens    = 4'hf;
        dt.hour_units   = 4'hf;
        dt.minute_tens  = 4'hf;
        dt.minute_units = 4'hf;
        dt.second_tens  = 4'hf;
        dt.second_units = 4'hf;
        send_item(dt);

        for (int n = 0; n < RandomItems; n++) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                well_formed++;
                send_item(make_date_time($urandom_range(1, 31), $urandom_range(1, 12),
                                         $urandom_range(0, 99), $urandom_range(0, 23),
                                         $urandom_range(0, 59), $urandom_range(0, 59)));
            end else if (kind < 17) begin
                for (int k = 0; k < 12; k++) begin
                    dt[4*k +: 4] = 4'($urandom_range(0, 9));
                end
                send_item(dt);
            end else begin
                send_item(48'({$urandom, $urandom}));
            end
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d items (%0d random well-formed dates), checked %0d results,",
                 items_sent, well_formed, results_checked);
        $display("%0d with bad month, output hold-off of %0d cycles done: %0b",
                 bad_month_results, HoldCycles, held_off);
        if (fail_count == 0 && pending_count == 0) begin
            $display("gnss_date_time_to_unix_seconds regression: pass");
        end else begin
            $display("gnss_date_time_to_unix_seconds regression: fail");
        end
        $finish;
    end

endmodule
